/* src/round_robin_task_table_defines.svh */
// Assertion macros shared by the round robin task table RTL.
`ifndef ROUND_ROBIN_TASK_TABLE_DEFINES_SVH
`define ROUND_ROBIN_TASK_TABLE_DEFINES_SVH

// Concurrent check on clk_i, suspended while reset is asserted.
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when the trigger holds, the consequence holds in the next cycle.
`define RTT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* src/rtt_pkg.sv */
// Package: slot states, command codes and fixed widths of the task table.
`default_nettype none

package rtt_pkg;

  // Default geometry
  localparam int unsigned SlotsDefault   = 8;
  localparam int unsigned IdWidthDefault = 16;

  // Fixed widths of the command and result fields
  localparam int unsigned ModeW = 3;
  localparam int unsigned CntW  = 4;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_SUSPENDED = 2'd2,
    ST_ZOMBIE    = 2'd3
  } slot_state_e;

  typedef enum logic [ModeW-1:0] {
    MODE_CREATE   = 3'd0,
    MODE_SUSPEND  = 3'd1,
    MODE_RESUME   = 3'd2,
    MODE_KILL     = 3'd3,
    MODE_SCHEDULE = 3'd4,
    MODE_CLEAN    = 3'd5
  } mode_e;

endpackage

`default_nettype wire

/* src/rtt_cell.sv */
// One slot cell of the rotating task ring: holds a state and an id.
`default_nettype none

module rtt_cell #(
  parameter int unsigned ID_WIDTH = rtt_pkg::IdWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 shift_i,
  input  wire rtt_pkg::slot_state_e state_i,
  input  wire logic [ID_WIDTH-1:0]  id_i,
  output rtt_pkg::slot_state_e      state_o,
  output logic      [ID_WIDTH-1:0]  id_o
);
  import rtt_pkg::*;

  slot_state_e         state_q;
  logic [ID_WIDTH-1:0] id_q;

  // Take the neighbour's state on each shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else if (shift_i) begin
      state_q <= state_i;
    end
  end

  // Id payload needs no reset: it is read only from non-empty slots
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q <= id_i;
    end
  end

  assign state_o = state_q;
  assign id_o    = id_q;

endmodule

`default_nettype wire

/* src/rtt_ctrl.sv */
// Command sequencer: works on the slot at the head of the ring, one per cycle.
`default_nettype none
`include "round_robin_task_table_defines.svh"

module rtt_ctrl #(
  parameter int unsigned SLOTS    = rtt_pkg::SlotsDefault,
  parameter int unsigned ID_WIDTH = rtt_pkg::IdWidthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rtt_pkg::ModeW-1:0] mode_i,
  input  wire logic [ID_WIDTH-1:0]       task_id_i,
  input  wire rtt_pkg::slot_state_e      head_state_i,
  input  wire logic [ID_WIDTH-1:0]       head_id_i,
  output logic                           shift_o,
  output rtt_pkg::slot_state_e           wb_state_o,
  output logic      [ID_WIDTH-1:0]       wb_id_o,
  output logic                           busy_o,
  output logic                           done_o,
  output logic                           ok_o,
  output logic      [ID_WIDTH-1:0]       result_id_o,
  output logic      [rtt_pkg::CntW-1:0]  count_active_o,
  output logic      [rtt_pkg::CntW-1:0]  count_running_o
);
  import rtt_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  // Control state
  logic                busy_q;
  logic [IdxW-1:0]     idx_q;
  logic [ModeW-1:0]    mode_q;
  logic [ID_WIDTH-1:0] tid_q;
  logic [ID_WIDTH-1:0] next_id_q, next_id_d;
  logic [IdxW-1:0]     last_served_q;
  logic                done_q;

  // Per-pass accumulators
  logic                match_q, match_d;
  logic                ok_q, ok_d;
  logic [ID_WIDTH-1:0] rid_q, rid_d;
  logic [CntW-1:0]     act_q, act_d;
  logic [CntW-1:0]     run_q, run_d;
  logic                a_hit_q, a_hit_d;
  logic [ID_WIDTH-1:0] a_id_q, a_id_d;
  logic [IdxW-1:0]     a_idx_q, a_idx_d;
  logic                b_hit_q, b_hit_d;
  logic [ID_WIDTH-1:0] b_id_q, b_id_d;
  logic [IdxW-1:0]     b_idx_q, b_idx_d;

  // Result registers
  logic                res_ok_q;
  logic [ID_WIDTH-1:0] res_id_q;
  logic [CntW-1:0]     res_act_q;
  logic [CntW-1:0]     res_run_q;

  slot_state_e         wb_state;
  logic [ID_WIDTH-1:0] wb_id;
  logic                accept;
  logic                last_step;

  assign accept    = start_i && !busy_q;
  assign last_step = busy_q && (idx_q == LastIdx);

  // Apply the command to the head slot and fold it into the accumulators
  always_comb begin
    wb_state  = head_state_i;
    wb_id     = head_id_i;
    match_d   = match_q;
    ok_d      = ok_q;
    rid_d     = rid_q;
    next_id_d = next_id_q;
    act_d     = act_q;
    run_d     = run_q;
    a_hit_d   = a_hit_q;
    a_id_d    = a_id_q;
    a_idx_d   = a_idx_q;
    b_hit_d   = b_hit_q;
    b_id_d    = b_id_q;
    b_idx_d   = b_idx_q;
    case (mode_q)
      MODE_CREATE: begin
        if (!match_q && head_state_i == ST_EMPTY) begin
          wb_state  = ST_RUNNING;
          wb_id     = next_id_q;
          match_d   = 1'b1;
          ok_d      = 1'b1;
          rid_d     = next_id_q;
          next_id_d = (next_id_q == '1) ? ID_WIDTH'(1) : next_id_q + ID_WIDTH'(1);
        end
      end
      MODE_SUSPEND, MODE_RESUME, MODE_KILL: begin
        if (!match_q && head_state_i != ST_EMPTY && head_id_i == tid_q) begin
          match_d = 1'b1;
          if (mode_q == MODE_KILL) begin
            wb_state = ST_ZOMBIE;
            ok_d     = 1'b1;
          end else if (mode_q == MODE_SUSPEND && head_state_i == ST_RUNNING) begin
            wb_state = ST_SUSPENDED;
            ok_d     = 1'b1;
          end else if (mode_q == MODE_RESUME && head_state_i == ST_SUSPENDED) begin
            wb_state = ST_RUNNING;
            ok_d     = 1'b1;
          end
        end
      end
      MODE_SCHEDULE: begin
        // Candidate after the last served slot, and first running overall as wrap
        if (head_state_i == ST_RUNNING) begin
          if (!a_hit_q && idx_q > last_served_q) begin
            a_hit_d = 1'b1;
            a_id_d  = head_id_i;
            a_idx_d = idx_q;
          end
          if (!b_hit_q) begin
            b_hit_d = 1'b1;
            b_id_d  = head_id_i;
            b_idx_d = idx_q;
          end
        end
      end
      MODE_CLEAN: begin
        ok_d = 1'b1;
        if (head_state_i == ST_ZOMBIE) begin
          wb_state = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
    if (wb_state == ST_RUNNING) begin
      run_d = run_q + CntW'(1);
      act_d = act_q + CntW'(1);
    end else if (wb_state == ST_SUSPENDED) begin
      act_d = act_q + CntW'(1);
    end
  end

  // Sequence the pass over the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      idx_q         <= '0;
      done_q        <= 1'b0;
      next_id_q     <= ID_WIDTH'(1);
      last_served_q <= LastIdx;
    end else begin
      done_q <= last_step;
      if (accept) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        next_id_q <= next_id_d;
        if (last_step) begin
          busy_q <= 1'b0;
          idx_q  <= '0;
          if (mode_q == MODE_SCHEDULE) begin
            if (a_hit_d) begin
              last_served_q <= a_idx_d;
            end else if (b_hit_d) begin
              last_served_q <= b_idx_d;
            end
          end
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
    end
  end

  // Hold the command and clear or advance the accumulators
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      tid_q   <= task_id_i;
      match_q <= 1'b0;
      ok_q    <= 1'b0;
      rid_q   <= '0;
      act_q   <= '0;
      run_q   <= '0;
      a_hit_q <= 1'b0;
      a_id_q  <= '0;
      a_idx_q <= '0;
      b_hit_q <= 1'b0;
      b_id_q  <= '0;
      b_idx_q <= '0;
    end else if (busy_q) begin
      match_q <= match_d;
      ok_q    <= ok_d;
      rid_q   <= rid_d;
      act_q   <= act_d;
      run_q   <= run_d;
      a_hit_q <= a_hit_d;
      a_id_q  <= a_id_d;
      a_idx_q <= a_idx_d;
      b_hit_q <= b_hit_d;
      b_id_q  <= b_id_d;
      b_idx_q <= b_idx_d;
    end
  end

  // Register the result at the end of the pass
  always_ff @(posedge clk_i) begin
    if (last_step) begin
      res_act_q <= act_d;
      res_run_q <= run_d;
      if (mode_q == MODE_SCHEDULE) begin
        res_ok_q <= a_hit_d || b_hit_d;
        res_id_q <= a_hit_d ? a_id_d : (b_hit_d ? b_id_d : '0);
      end else begin
        res_ok_q <= ok_d;
        res_id_q <= rid_d;
      end
    end
  end

  assign shift_o         = busy_q;
  assign wb_state_o      = wb_state;
  assign wb_id_o         = wb_id;
  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign ok_o            = res_ok_q;
  assign result_id_o     = res_id_q;
  assign count_active_o  = res_act_q;
  assign count_running_o = res_run_q;

  `RTT_ASSERT_NEXT(a_pass_ends, last_step, done_q && !busy_q, "pass did not end in a result")
  `RTT_ASSERT_NEXT(a_accept_starts, accept, busy_q && idx_q == '0, "accepted command not started")
  `RTT_ASSERT(a_idle_idx, !busy_q |-> idx_q == '0, "slot index not rewound when idle")
  `RTT_ASSERT(a_id_nonzero, next_id_q != '0, "id counter reached zero")
  `RTT_ASSERT(a_done_idle, done_q |-> !busy_q, "result strobed during a pass")

endmodule

`default_nettype wire

/* src/round_robin_task_table.sv */
// Top level: ring of slot cells rotated by the command sequencer.
//
//   Channel   Handshake        Ports
//   command   start & !busy    mode_i, task_id_i
//   result    done_o strobe    ok_o, result_id_o, count_active_o, count_running_o
//
// Each command rotates the ring of SLOTS cells once, one slot past the head per
// cycle, with busy high throughout, and the result is strobed on done_o in the
// cycle after the last busy cycle; the next command may start in that cycle.
// The single-slot sequencer at the ring head sets this pace.
// Reset (asynchronous, active low) empties every slot, sets the id counter to one
// and the last served slot to the highest index; no clearing pass is needed.
// The done_o strobe is high for one cycle only; the receiver cannot stall it.
`default_nettype none

module round_robin_task_table #(
  parameter int unsigned SLOTS    = rtt_pkg::SlotsDefault,
  parameter int unsigned ID_WIDTH = rtt_pkg::IdWidthDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [rtt_pkg::ModeW-1:0] mode_i,
  input  wire logic [ID_WIDTH-1:0]       task_id_i,
  output logic                           done_o,
  output logic                           ok_o,
  output logic      [ID_WIDTH-1:0]       result_id_o,
  output logic      [rtt_pkg::CntW-1:0]  count_active_o,
  output logic      [rtt_pkg::CntW-1:0]  count_running_o
);
  import rtt_pkg::*;

  // Chain taps: entry k is the output of cell k, entry SLOTS the write-back
  slot_state_e         chain_state [SLOTS+1];
  logic [ID_WIDTH-1:0] chain_id    [SLOTS+1];
  logic                shift;

  // Build the ring of cells, each taking from its upper neighbour
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    rtt_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .state_i (chain_state[k+1]),
      .id_i    (chain_id[k+1]),
      .state_o (chain_state[k]),
      .id_o    (chain_id[k])
    );
  end

  rtt_ctrl #(
    .SLOTS    (SLOTS),
    .ID_WIDTH (ID_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .mode_i          (mode_i),
    .task_id_i       (task_id_i),
    .head_state_i    (chain_state[0]),
    .head_id_i       (chain_id[0]),
    .shift_o         (shift),
    .wb_state_o      (chain_state[SLOTS]),
    .wb_id_o         (chain_id[SLOTS]),
    .busy_o          (busy),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .result_id_o     (result_id_o),
    .count_active_o  (count_active_o),
    .count_running_o (count_running_o)
  );

endmodule

`default_nettype wire
